FILE: sv/rsr_pkg.sv
// Shared constants, register codes and types for the Rossler RK2 integrator.
`default_nettype none

package rsr_pkg;

    localparam int FIELD_BITS     = 48;
    localparam int DT_BITS        = 47;
    localparam int CFG_IDX_BITS   = 3;
    localparam int DEF_WORD_BITS  = 48;
    localparam int DEF_FRAC_BITS  = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_A       = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_B       = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_C       = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_SIZE    = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_START = CFG_IDX_BITS'(4);
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_END   = CFG_IDX_BITS'(5);

    // reset values, Q16.32
    localparam logic signed [FIELD_BITS-1:0] RST_COEF_A       = 48'sd429496730;
    localparam logic signed [FIELD_BITS-1:0] RST_COEF_B       = 48'sd429496730;
    localparam logic signed [FIELD_BITS-1:0] RST_COEF_C       = 48'sd4294967296;
    localparam logic [DT_BITS-1:0]           RST_STEP_SIZE    = 47'd429497;
    localparam logic [FIELD_BITS-1:0]        RST_WINDOW_START = 48'd8113193222144;
    localparam logic [FIELD_BITS-1:0]        RST_WINDOW_END   = 48'd8594229559296;

    typedef struct packed {
        logic clear;   // restart: forget all maxima
        logic eval;    // step commit: look for a maximum
        logic in_win;  // new time lies inside the window
    } t_peak_ctl;

endpackage

`default_nettype wire

FILE: sv/rossler_rk2_step_period_detect.sv
// Rossler system RK2 integrator with per-variable period detection, top level.
//
// Input channel (i_valid/o_ready) carries one command per transfer: i_cmd = 0
// advances one RK2 step of size step_size, i_cmd = 1 loads i_init_x/y/z and
// restarts time and the peak trackers. Each transfer gives exactly one result
// on the output channel (o_valid/i_ready): position, time, three periods and
// their valid flags. Configuration (i_cfg_valid/o_cfg_ready, index, data) is
// always ready and must only be written while no command is in flight.
// A load goes straight from idle to the output state. Each advance sends
// twelve products through the single iterative multiplier and seventeen
// saturating adds through the adder; the ST_TIME, ST_PEAK and ST_OUT states
// do the bookkeeping. One command is in flight at a time; o_ready is high
// only while the sequencer is idle, so a new command is taken only once the
// last one has left the sequencer.
// The result sits in an output register; a new command is taken while it
// waits, but the next result is held back until the receiver takes it.
// Reset (synchronous, active low) zeroes position, time and trackers and
// restores the default coefficients, step and window.
`default_nettype none

module rossler_rk2_step_period_detect #(
    parameter int WORD_BITS = rsr_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = rsr_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [rsr_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire logic [rsr_pkg::FIELD_BITS-1:0]        i_cfg_data,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic                                  i_cmd,
    input  wire logic signed [rsr_pkg::FIELD_BITS-1:0] i_init_x,
    input  wire logic signed [rsr_pkg::FIELD_BITS-1:0] i_init_y,
    input  wire logic signed [rsr_pkg::FIELD_BITS-1:0] i_init_z,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic signed [rsr_pkg::FIELD_BITS-1:0]      o_pos_x,
    output logic signed [rsr_pkg::FIELD_BITS-1:0]      o_pos_y,
    output logic signed [rsr_pkg::FIELD_BITS-1:0]      o_pos_z,
    output logic [rsr_pkg::FIELD_BITS-1:0]             o_sim_time,
    output logic [rsr_pkg::FIELD_BITS-1:0]             o_period_x,
    output logic [rsr_pkg::FIELD_BITS-1:0]             o_period_y,
    output logic [rsr_pkg::FIELD_BITS-1:0]             o_period_z,
    output logic                                       o_valid_x,
    output logic                                       o_valid_y,
    output logic                                       o_valid_z
);
    import rsr_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int TW = (W > FIELD_BITS) ? W : FIELD_BITS;
    localparam int XW = TW + 1;

    localparam logic signed [W-1:0] VMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic [XW-1:0]       VMAX_U = XW'({1'b0, {(W-1){1'b1}}});

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FX   = 4'd1;
    localparam logic [3:0] ST_MAY  = 4'd2;
    localparam logic [3:0] ST_FY   = 4'd3;
    localparam logic [3:0] ST_MXZ  = 4'd4;
    localparam logic [3:0] ST_FZB  = 4'd5;
    localparam logic [3:0] ST_MCZ  = 4'd6;
    localparam logic [3:0] ST_FZC  = 4'd7;
    localparam logic [3:0] ST_KMUL = 4'd8;
    localparam logic [3:0] ST_UPD1 = 4'd9;
    localparam logic [3:0] ST_UPD2 = 4'd10;
    localparam logic [3:0] ST_TIME = 4'd11;
    localparam logic [3:0] ST_PEAK = 4'd12;
    localparam logic [3:0] ST_OUT  = 4'd13;

    function automatic logic signed [W-1:0] clamp_field(input logic signed [FIELD_BITS-1:0] v);
        logic signed [XW-1:0] vx;
        vx = XW'(v);
        if (vx > XW'(VMAX)) return VMAX;
        if (vx < XW'(VMIN)) return VMIN;
        return W'(vx);
    endfunction

    function automatic logic signed [W-1:0] clamp_dt(input logic [DT_BITS-1:0] v);
        logic [XW-1:0] vx;
        vx = XW'(v);
        if (vx > VMAX_U) return VMAX;
        return $signed(W'(vx));
    endfunction

    function automatic logic signed [W-1:0] sat_word(input logic signed [W+1:0] s);
        if (s > (W+2)'(VMAX)) return VMAX;
        if (s < (W+2)'(VMIN)) return VMIN;
        return W'(s);
    endfunction

    function automatic logic [FIELD_BITS-1:0] field_s(input logic signed [W-1:0] v);
        logic signed [TW-1:0] e;
        e = TW'(v);
        return e[FIELD_BITS-1:0];
    endfunction

    function automatic logic [FIELD_BITS-1:0] field_u(input logic [W-1:0] v);
        logic [TW-1:0] e;
        e = TW'(v);
        return e[FIELD_BITS-1:0];
    endfunction

    // configuration
    logic signed [W-1:0]   r_coef_a;
    logic signed [W-1:0]   r_coef_b;
    logic signed [W-1:0]   r_coef_c;
    logic signed [W-1:0]   r_dt;
    logic [FIELD_BITS-1:0] r_win_start;
    logic [FIELD_BITS-1:0] r_win_end;

    // sequencer
    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [3:0] w_next_var_st;
    logic       r_pass;
    logic [1:0] r_var;
    logic       r_mul_busy;

    // datapath state and scratch
    logic signed [W-1:0] r_cur  [0:2];
    logic signed [W-1:0] r_prev [0:2];
    logic signed [W-1:0] r_mid  [0:2];
    logic signed [W-1:0] r_k1   [0:2];
    logic signed [W-1:0] r_nxt  [0:2];
    logic signed [W-1:0] r_m;
    logic signed [W-1:0] r_f;
    logic signed [W-1:0] r_k;
    logic [W-1:0]        r_time;

    // output register
    logic                  r_o_valid;
    logic [FIELD_BITS-1:0] r_o_pos    [0:2];
    logic [FIELD_BITS-1:0] r_o_period [0:2];
    logic [2:0]            r_o_pv;
    logic [FIELD_BITS-1:0] r_o_time;

    logic                w_in_acc;
    logic                w_out_free;
    logic                w_is_mul;
    logic                w_var_done;
    logic                w_mul_start;
    logic                w_mul_done;
    logic signed [W-1:0] w_mul_a;
    logic signed [W-1:0] w_mul_b;
    logic signed [W-1:0] w_mul_p;
    logic signed [W-1:0] w_opx;
    logic signed [W-1:0] w_opy;
    logic signed [W-1:0] w_opz;
    logic signed [W-1:0] w_alu_a;
    logic signed [W-1:0] w_alu_b;
    logic [1:0]          w_alu_cin;
    logic signed [W+1:0] w_alu_sum;
    logic signed [W-1:0] w_alu;
    logic [W:0]          w_tsum;
    logic [TW-1:0]       w_tx;
    logic                w_in_win;
    t_peak_ctl           w_pctl;
    logic [W-1:0]        w_period [0:2];
    logic [2:0]          w_pvalid;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign w_in_acc    = i_valid && o_ready;
    assign w_out_free  = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a    <= clamp_field(RST_COEF_A);
            r_coef_b    <= clamp_field(RST_COEF_B);
            r_coef_c    <= clamp_field(RST_COEF_C);
            r_dt        <= clamp_dt(RST_STEP_SIZE);
            r_win_start <= RST_WINDOW_START;
            r_win_end   <= RST_WINDOW_END;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_COEF_A:       r_coef_a    <= clamp_field($signed(i_cfg_data));
                CFG_COEF_B:       r_coef_b    <= clamp_field($signed(i_cfg_data));
                CFG_COEF_C:       r_coef_c    <= clamp_field($signed(i_cfg_data));
                CFG_STEP_SIZE:    r_dt        <= clamp_dt(i_cfg_data[DT_BITS-1:0]);
                CFG_WINDOW_START: r_win_start <= i_cfg_data;
                CFG_WINDOW_END:   r_win_end   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // operands of f(): current point on the first pass, midpoint on the second
    assign w_opx = r_pass ? r_mid[0] : r_cur[0];
    assign w_opy = r_pass ? r_mid[1] : r_cur[1];
    assign w_opz = r_pass ? r_mid[2] : r_cur[2];

    assign w_is_mul = (r_state == ST_MAY) || (r_state == ST_MXZ) ||
                      (r_state == ST_MCZ) || (r_state == ST_KMUL);
    assign w_mul_start = w_is_mul && !r_mul_busy;

    always_comb begin
        case (r_state)
            ST_MAY: begin
                w_mul_a = r_coef_a;
                w_mul_b = w_opy;
            end
            ST_MXZ: begin
                w_mul_a = w_opx;
                w_mul_b = w_opz;
            end
            ST_MCZ: begin
                w_mul_a = r_coef_c;
                w_mul_b = w_opz;
            end
            default: begin
                w_mul_a = r_f;
                w_mul_b = r_dt;
            end
        endcase
    end

    rsr_mul #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_p)
    );

    // saturating adder: negation is ~v plus a carry, so -v and sneg share it
    always_comb begin
        w_alu_a   = '0;
        w_alu_b   = '0;
        w_alu_cin = 2'd0;
        case (r_state)
            ST_FX: begin
                w_alu_a   = ~w_opy;
                w_alu_b   = ~w_opz;
                w_alu_cin = 2'(w_opy != VMIN) + (r_pass ? 2'(w_opz != VMIN) : 2'd1);
            end
            ST_FY: begin
                w_alu_a = w_opx;
                w_alu_b = r_m;
            end
            ST_FZB: begin
                w_alu_a = r_coef_b;
                w_alu_b = r_m;
            end
            ST_FZC: begin
                w_alu_a   = r_f;
                w_alu_b   = ~r_m;
                w_alu_cin = 2'd1;
            end
            ST_UPD1: begin
                if (r_pass) begin
                    w_alu_a = r_k1[r_var];
                    w_alu_b = r_k;
                end else begin
                    w_alu_a = r_cur[r_var];
                    w_alu_b = r_k >>> 1;
                end
            end
            ST_UPD2: begin
                w_alu_a = r_cur[r_var];
                w_alu_b = r_f >>> 1;
            end
            default: begin
            end
        endcase
    end

    assign w_alu_sum = (W+2)'(w_alu_a) + (W+2)'(w_alu_b) + (W+2)'(w_alu_cin);
    assign w_alu     = sat_word(w_alu_sum);

    assign w_tsum   = {1'b0, r_time} + {1'b0, $unsigned(r_dt)};
    assign w_tx     = TW'(r_time);
    assign w_in_win = (w_tx > TW'(r_win_start)) && (w_tx < TW'(r_win_end));

    assign w_var_done = ((r_state == ST_UPD1) && !r_pass) || (r_state == ST_UPD2);

    always_comb begin
        case (r_var)
            2'd0:    w_next_var_st = ST_MAY;
            2'd1:    w_next_var_st = ST_MXZ;
            default: w_next_var_st = r_pass ? ST_TIME : ST_FX;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_acc) n_state = i_cmd ? ST_OUT : ST_FX;
            ST_FX:   n_state = ST_KMUL;
            ST_MAY:  if (w_mul_done) n_state = ST_FY;
            ST_FY:   n_state = ST_KMUL;
            ST_MXZ:  if (w_mul_done) n_state = ST_FZB;
            ST_FZB:  n_state = ST_MCZ;
            ST_MCZ:  if (w_mul_done) n_state = ST_FZC;
            ST_FZC:  n_state = ST_KMUL;
            ST_KMUL: if (w_mul_done) n_state = ST_UPD1;
            ST_UPD1: n_state = r_pass ? ST_UPD2 : w_next_var_st;
            ST_UPD2: n_state = w_next_var_st;
            ST_TIME: n_state = ST_PEAK;
            ST_PEAK: n_state = ST_OUT;
            ST_OUT:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pass     <= 1'b0;
            r_var      <= 2'd0;
            r_mul_busy <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_mul_start) begin
                r_mul_busy <= 1'b1;
            end else if (w_mul_done) begin
                r_mul_busy <= 1'b0;
            end
            if (w_in_acc) begin
                r_pass <= 1'b0;
                r_var  <= 2'd0;
            end else if (w_var_done) begin
                if (r_var == 2'd2) begin
                    r_var  <= 2'd0;
                    r_pass <= 1'b1;
                end else begin
                    r_var <= r_var + 2'd1;
                end
            end
        end
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_cur[i]  <= '0;
                r_prev[i] <= '0;
            end
            r_time <= '0;
        end else if (w_in_acc && i_cmd) begin
            r_cur[0]  <= clamp_field(i_init_x);
            r_cur[1]  <= clamp_field(i_init_y);
            r_cur[2]  <= clamp_field(i_init_z);
            r_prev[0] <= clamp_field(i_init_x);
            r_prev[1] <= clamp_field(i_init_y);
            r_prev[2] <= clamp_field(i_init_z);
            r_time    <= '0;
        end else if (r_state == ST_TIME) begin
            r_time <= w_tsum[W] ? {W{1'b1}} : w_tsum[W-1:0];
        end else if (r_state == ST_PEAK) begin
            for (int i = 0; i < 3; i++) begin
                r_prev[i] <= r_cur[i];
                r_cur[i]  <= r_nxt[i];
            end
        end
    end

    // scratch registers
    always_ff @(posedge i_clk) begin
        if (w_mul_done) begin
            if (r_state == ST_KMUL) begin
                r_k <= w_mul_p;
            end else begin
                r_m <= w_mul_p;
            end
        end
        case (r_state)
            ST_FX, ST_FY, ST_FZB, ST_FZC: begin
                r_f <= w_alu;
            end
            ST_UPD1: begin
                if (r_pass) begin
                    r_f <= w_alu;
                end else begin
                    r_mid[r_var] <= w_alu;
                    r_k1[r_var]  <= r_k;
                end
            end
            ST_UPD2: begin
                r_nxt[r_var] <= w_alu;
            end
            default: begin
            end
        endcase
    end

    assign w_pctl.clear  = w_in_acc && i_cmd;
    assign w_pctl.eval   = (r_state == ST_PEAK);
    assign w_pctl.in_win = w_in_win;

    for (genvar g = 0; g < 3; g++) begin : g_peak
        rsr_peak #(
            .WORD_BITS (WORD_BITS)
        ) u_peak (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_pctl),
            .i_cur    (r_cur[g]),
            .i_prev   (r_prev[g]),
            .i_nxt    (r_nxt[g]),
            .i_time   (r_time),
            .o_period (w_period[g]),
            .o_valid  (w_pvalid[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && w_out_free) begin
            for (int i = 0; i < 3; i++) begin
                r_o_pos[i]    <= field_s(r_cur[i]);
                r_o_period[i] <= field_u(w_period[i]);
            end
            r_o_pv   <= w_pvalid;
            r_o_time <= field_u(r_time);
        end
    end

    assign o_valid    = r_o_valid;
    assign o_pos_x    = $signed(r_o_pos[0]);
    assign o_pos_y    = $signed(r_o_pos[1]);
    assign o_pos_z    = $signed(r_o_pos[2]);
    assign o_sim_time = r_o_time;
    assign o_period_x = r_o_period[0];
    assign o_period_y = r_o_period[1];
    assign o_period_z = r_o_period[2];
    assign o_valid_x  = r_o_pv[0];
    assign o_valid_y  = r_o_pv[1];
    assign o_valid_z  = r_o_pv[2];

`ifndef SYNTHESIS
    a_mul_done_in_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == ST_MAY || r_state == ST_MXZ ||
                        r_state == ST_MCZ || r_state == ST_KMUL))
        else $error("multiplier finished outside a multiply step");

    a_var_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_var != 2'd3)
        else $error("variable index out of range");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_o_valid && !i_ready) |=> (r_state == ST_OUT))
        else $error("result overwritten before transfer");

    a_load_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_cmd) |=> (r_time == '0 && r_state == ST_OUT && w_pvalid == 3'b000))
        else $error("load did not restart time and trackers");

    a_valid_falls_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(w_pvalid[0]) |-> $past(w_in_acc && i_cmd))
        else $error("period flag dropped without a load");
`endif

endmodule

`default_nettype wire

FILE: sv/rsr_mul.sv
// Iterative signed fixed-point multiplier: four half-width partial products, truncate, saturate.
`default_nettype none

module rsr_mul #(
    parameter int WORD_BITS = rsr_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = rsr_pkg::DEF_FRAC_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic signed [WORD_BITS-1:0] i_a,
    input  wire logic signed [WORD_BITS-1:0] i_b,
    output logic                             o_done,
    output logic signed [WORD_BITS-1:0]      o_prod
);
    import rsr_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int H  = (W + 1) / 2;
    localparam int AW = 4 * H;
    localparam int QA = AW - FRAC_BITS + 1;
    localparam int QX = (QA > W + 1) ? QA : W + 1;

    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_PP   = 2'd1;
    localparam logic [1:0] M_RND  = 2'd2;
    localparam logic [1:0] M_SAT  = 2'd3;

    logic [1:0]          r_mst;
    logic [1:0]          r_cnt;
    logic                r_done;
    logic                r_neg;
    logic [2*H-1:0]      r_ua;
    logic [2*H-1:0]      r_ub;
    logic [AW-1:0]       r_acc;
    logic [QX-1:0]       r_q;
    logic signed [W-1:0] r_prod;

    logic [W-1:0]   w_ma;
    logic [W-1:0]   w_mb;
    logic [H-1:0]   w_pa;
    logic [H-1:0]   w_pb;
    logic [2*H-1:0] w_pp;
    logic [AW-1:0]  w_sh;
    logic           w_round;
    logic           w_sat;

    assign w_ma = i_a[W-1] ? $unsigned(-i_a) : $unsigned(i_a);
    assign w_mb = i_b[W-1] ? $unsigned(-i_b) : $unsigned(i_b);

    assign w_pa = r_cnt[0] ? r_ua[2*H-1:H] : r_ua[H-1:0];
    assign w_pb = r_cnt[1] ? r_ub[2*H-1:H] : r_ub[H-1:0];
    assign w_pp = w_pa * w_pb;

    always_comb begin
        case (r_cnt)
            2'd0:    w_sh = AW'(w_pp);
            2'd1:    w_sh = AW'(w_pp) << H;
            2'd2:    w_sh = AW'(w_pp) << H;
            default: w_sh = AW'(w_pp) << (2 * H);
        endcase
    end

    // negative products round toward minus infinity: bump the magnitude
    assign w_round = r_neg & (|r_acc[FRAC_BITS-1:0]);
    assign w_sat   = |r_q[QX-1:W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mst  <= M_IDLE;
            r_cnt  <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_mst)
                M_IDLE: begin
                    if (i_start) begin
                        r_mst <= M_PP;
                        r_cnt <= 2'd0;
                    end
                end
                M_PP: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_mst <= M_RND;
                    end
                end
                M_RND: begin
                    r_mst <= M_SAT;
                end
                M_SAT: begin
                    r_mst  <= M_IDLE;
                    r_done <= 1'b1;
                end
                default: begin
                    r_mst <= M_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_mst)
            M_IDLE: begin
                if (i_start) begin
                    r_ua  <= (2*H)'(w_ma);
                    r_ub  <= (2*H)'(w_mb);
                    r_neg <= i_a[W-1] ^ i_b[W-1];
                    r_acc <= '0;
                end
            end
            M_PP: begin
                r_acc <= r_acc + w_sh;
            end
            M_RND: begin
                r_q <= QX'(r_acc >> FRAC_BITS) + QX'(w_round);
            end
            M_SAT: begin
                if (w_sat) begin
                    r_prod <= r_neg ? VMIN : VMAX;
                end else if (r_neg) begin
                    r_prod <= $signed(-r_q[W-1:0]);
                end else begin
                    r_prod <= $signed(r_q[W-1:0]);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

FILE: sv/rsr_peak.sv
// Local-maximum tracker for one state variable: first peak time and period.
`default_nettype none

module rsr_peak #(
    parameter int WORD_BITS = rsr_pkg::DEF_WORD_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rsr_pkg::t_peak_ctl          i_ctl,
    input  wire logic signed [WORD_BITS-1:0] i_cur,
    input  wire logic signed [WORD_BITS-1:0] i_prev,
    input  wire logic signed [WORD_BITS-1:0] i_nxt,
    input  wire logic [WORD_BITS-1:0]        i_time,
    output logic [WORD_BITS-1:0]             o_period,
    output logic                             o_valid
);
    import rsr_pkg::*;

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    logic [1:0]           r_phase;
    logic [WORD_BITS-1:0] r_first;
    logic [WORD_BITS-1:0] r_period;

    logic w_hit;

    assign w_hit = i_ctl.eval && i_ctl.in_win && (i_cur > i_nxt) && (i_cur > i_prev);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_NONE;
            r_period <= '0;
        end else if (i_ctl.clear) begin
            r_phase  <= PH_NONE;
            r_period <= '0;
        end else if (w_hit) begin
            case (r_phase)
                PH_NONE: begin
                    r_phase <= PH_ONE;
                end
                PH_ONE: begin
                    r_phase  <= PH_DONE;
                    r_period <= (i_time >= r_first) ? i_time - r_first : '0;
                end
                default: begin
                end
            endcase
        end
    end

    // first peak time is only read once written
    always_ff @(posedge i_clk) begin
        if (w_hit && !i_ctl.clear && r_phase == PH_NONE) begin
            r_first <= i_time;
        end
    end

    assign o_period = r_period;
    assign o_valid  = (r_phase == PH_DONE);

endmodule

`default_nettype wire
